>>> sv/keypad_setpoint_editor_assert.svh
// Assertion helpers for the setpoint editor; clk_i and rst_ni are taken from scope.
`ifndef KEYPAD_SETPOINT_EDITOR_ASSERT_SVH
`define KEYPAD_SETPOINT_EDITOR_ASSERT_SVH

// same-cycle implication
`define KSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/kse_pkg.sv
package kse_pkg;

  // key indices within a tick
  localparam int unsigned KEY_MINUS = 0;
  localparam int unsigned KEY_PLUS  = 1;
  localparam int unsigned NUM_KEYS  = 4;

  // hold timer thresholds in ms
  localparam int unsigned SHORT_MS       = 1500;
  localparam int unsigned REPEAT_LOW_MS  = 1900;
  localparam int unsigned REPEAT_HIGH_MS = 2100;
  localparam int unsigned HOLD_END_MS    = 3000;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SPEED = 2'd1;
  localparam logic [1:0] MODE_TIME  = 2'd2;

  localparam logic [1:0] BLINK_NONE = 2'd0;
  localparam logic [1:0] BLINK_EDIT = 2'd1;
  localparam logic [1:0] BLINK_MENU = 2'd2;

  // register map, index = paddr[2]
  localparam logic REG_TICK_MS    = 1'b0;
  localparam logic REG_TIME_STYLE = 1'b1;

  localparam logic [9:0] TICK_MS_RST = 10'd10;

  localparam logic [6:0] SPEED_MIN    = 7'd10;
  localparam logic [6:0] SPEED_MAX    = 7'd80;
  localparam logic [6:0] SPEED_FINE   = 7'd1;
  localparam logic [6:0] SPEED_COARSE = 7'd10;

  localparam logic [14:0] TIME_LIMIT = 15'd28800;

  typedef struct packed {
    logic [1:0] arrow_short;   // minus, plus released before 1.5 s
    logic [1:0] arrow_rep;     // minus, plus auto-repeat
    logic [1:0] action_short;  // start, menu released before 1.5 s
    logic [1:0] action_beep;   // start, menu hold beep
    logic       coarse;
  } kse_evt_t;

endpackage

>>> sv/kse_if.sv
interface kse_tick_if;
  logic valid;
  logic ready;
  logic key_minus_level;
  logic key_plus_level;
  logic key_start_level;
  logic key_menu_level;
  logic coarse_unit;

  modport source (
    output valid, key_minus_level, key_plus_level, key_start_level, key_menu_level,
           coarse_unit,
    input  ready
  );
  modport sink (
    input  valid, key_minus_level, key_plus_level, key_start_level, key_menu_level,
           coarse_unit,
    output ready
  );
endinterface

interface kse_result_if;
  logic        valid;
  logic        ready;
  logic [6:0]  speed_setpoint;
  logic [14:0] time_setpoint;
  logic [1:0]  edit_mode;
  logic        running;
  logic        run_started;
  logic        value_edited;
  logic [1:0]  blink_code;
  logic        short_beep;
  logic        double_beep;

  modport source (
    output valid, speed_setpoint, time_setpoint, edit_mode, running, run_started,
           value_edited, blink_code, short_beep, double_beep,
    input  ready
  );
  modport sink (
    input  valid, speed_setpoint, time_setpoint, edit_mode, running, run_started,
           value_edited, blink_code, short_beep, double_beep,
    output ready
  );
endinterface

>>> sv/kse_front.sv
module kse_front #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kse_tick_if.sink          tick_i,
  input  logic [9:0]        tick_ms_i,
  input  logic              q_full_i,
  output logic              push_o,
  output kse_pkg::kse_evt_t evt_o
);
  import kse_pkg::*;

  localparam logic [TIMER_BITS-1:0] T_SHORT = TIMER_BITS'(SHORT_MS);
  localparam logic [TIMER_BITS-1:0] T_RLOW  = TIMER_BITS'(REPEAT_LOW_MS);
  localparam logic [TIMER_BITS-1:0] T_RHIGH = TIMER_BITS'(REPEAT_HIGH_MS);
  localparam logic [TIMER_BITS-1:0] T_HEND  = TIMER_BITS'(HOLD_END_MS);

  logic [TIMER_BITS-1:0] timer_q [NUM_KEYS];
  logic [TIMER_BITS-1:0] timer_d [NUM_KEYS];
  logic [TIMER_BITS-1:0] tsat    [NUM_KEYS];
  logic [TIMER_BITS-1:0] t1      [NUM_KEYS];
  logic [TIMER_BITS:0]   tsum    [NUM_KEYS];
  logic [NUM_KEYS-1:0]   seen_q, seen_d, lvl, pr;
  logic [1:0]            latch_q, latch_d;
  logic                  accept;

  assign lvl    = {tick_i.key_menu_level, tick_i.key_start_level,
                   tick_i.key_plus_level, tick_i.key_minus_level};
  assign tick_i.ready = !q_full_i;
  assign accept = tick_i.valid && !q_full_i;
  assign push_o = accept;

  // saturating timer add; a latched action key stops counting
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      tsum[k] = {1'b0, timer_q[k]} + (TIMER_BITS + 1)'(tick_ms_i);
      tsat[k] = tsum[k][TIMER_BITS] ? '1 : tsum[k][TIMER_BITS-1:0];
    end
    pr[1:0] = ~lvl[1:0];
    pr[3:2] = ~lvl[3:2] & ~latch_q;
    for (int k = 0; k < NUM_KEYS; k++) begin
      t1[k] = pr[k] ? tsat[k] : timer_q[k];
    end
  end

  always_comb begin
    evt_o        = '0;
    evt_o.coarse = tick_i.coarse_unit;
    latch_d      = latch_q;
    for (int k = 0; k < 2; k++) begin
      timer_d[k] = t1[k];
      seen_d[k]  = seen_q[k] | pr[k];
      if (seen_d[k]) begin
        if (lvl[k]) begin
          evt_o.arrow_short[k] = t1[k] < T_SHORT;
          seen_d[k]  = 1'b0;
          timer_d[k] = '0;
        end else if (t1[k] > T_RLOW && t1[k] < T_RHIGH) begin
          evt_o.arrow_rep[k] = 1'b1;
          seen_d[k]  = 1'b0;
          timer_d[k] = T_SHORT;
        end
      end
    end
    for (int j = 0; j < 2; j++) begin
      timer_d[j+2] = t1[j+2];
      seen_d[j+2]  = seen_q[j+2] | pr[j+2];
      if (seen_d[j+2]) begin
        if (lvl[j+2]) begin
          evt_o.action_short[j] = t1[j+2] < T_SHORT;
          seen_d[j+2]  = 1'b0;
          latch_d[j]   = 1'b0;
          timer_d[j+2] = '0;
        end else if (t1[j+2] > T_SHORT && t1[j+2] < T_HEND && !latch_q[j]) begin
          evt_o.action_beep[j] = 1'b1;
          latch_d[j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        timer_q[k] <= '0;
      end
      seen_q  <= '0;
      latch_q <= '0;
    end else if (accept) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        timer_q[k] <= timer_d[k];
      end
      seen_q  <= seen_d;
      latch_q <= latch_d;
    end
  end

endmodule

>>> sv/kse_queue.sv
module kse_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kse_pkg::kse_evt_t push_data_i,
  input  logic              pop_i,
  output kse_pkg::kse_evt_t pop_data_o,
  output logic              full_o,
  output logic              empty_o
);
  import kse_pkg::*;

  kse_evt_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

>>> sv/kse_back.sv
module kse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              time_style_i,
  input  kse_pkg::kse_evt_t evt_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  kse_result_if.source      result_o
);
  import kse_pkg::*;

  localparam logic signed [16:0] T_ZERO  = 17'sd0;
  localparam logic signed [16:0] T_ONE   = 17'sd1;
  localparam logic signed [16:0] T_TEN   = 17'sd10;
  localparam logic signed [16:0] T_59    = 17'sd59;
  localparam logic signed [16:0] T_MIN   = 17'sd60;
  localparam logic signed [16:0] T_10MIN = 17'sd600;
  localparam logic signed [16:0] T_HOUR  = 17'sd3600;
  localparam logic signed [16:0] T_MAXS  = 17'sd5940;
  localparam logic signed [16:0] T_MAXH  = 17'sd28800;

  function automatic logic [6:0] speed_step(logic up, logic held, logic [6:0] cur);
    logic [6:0] d;
    logic [6:0] s;
    d = held ? SPEED_COARSE : SPEED_FINE;
    s = up ? cur + d : cur - d;
    if (s < SPEED_MIN) s = SPEED_MIN;
    if (s > SPEED_MAX) s = SPEED_MAX;
    return s;
  endfunction

  function automatic logic [14:0] time_step(logic style, logic up, logic held,
                                            logic coarse, logic [14:0] cur);
    logic signed [16:0] t;
    t = signed'({2'b00, cur});
    if (style) begin
      if (up) begin
        if (coarse) begin
          t = t + T_HOUR;
        end else if (held) begin
          t = t + T_10MIN;
          if (t > T_HOUR) t = T_HOUR;
        end else begin
          t = t + T_MIN;
        end
        if (t > T_MAXH) t = T_MAXH;
      end else begin
        if (coarse) t = t - ((t == T_HOUR) ? T_MIN : T_HOUR);
        else        t = t - (held ? T_10MIN : T_MIN);
        if (t < T_MIN) t = T_ZERO;
      end
    end else begin
      if (up) begin
        // empty timer: a fine step jumps straight to a minute
        if (t == T_ZERO) t = t + (held ? T_MIN : T_59);
        if (!coarse) begin
          t = t + (held ? T_TEN : T_ONE);
          if (held && t > T_MIN) t = T_MIN;
        end else begin
          t = t + (held ? T_10MIN : T_MIN);
        end
        if (t > T_MAXS) t = T_MAXS;
      end else begin
        if (held) t = t - (coarse ? T_10MIN : T_TEN);
        else      t = t - ((t <= T_MIN) ? T_ONE : T_MIN);
        if (t < T_ONE) t = T_ZERO;
      end
    end
    return t[14:0];
  endfunction

  logic [1:0]  mode_q, mode_d;
  logic [6:0]  speed_q, speed_d;
  logic [14:0] time_q, time_d;
  logic        run_q, run_d;
  logic        started, edited, short_b, double_b;
  logic [1:0]  blink;
  logic        held;
  logic        out_valid_q;

  assign pop_o = !q_empty_i && (!out_valid_q || result_o.ready);

  // minus, plus, start, menu in that order
  always_comb begin
    mode_d   = mode_q;
    speed_d  = speed_q;
    time_d   = time_q;
    run_d    = run_q;
    started  = 1'b0;
    edited   = 1'b0;
    short_b  = 1'b0;
    double_b = |evt_i.action_beep;
    blink    = BLINK_NONE;
    held     = 1'b0;
    for (int k = 0; k < 2; k++) begin
      held = evt_i.arrow_rep[k];
      if (evt_i.arrow_short[k] || evt_i.arrow_rep[k]) begin
        unique case (mode_q)
          MODE_SPEED: begin
            speed_d = speed_step(k == KEY_PLUS, held, speed_d);
            edited  = 1'b1;
            blink   = BLINK_EDIT;
          end
          MODE_TIME: begin
            time_d = time_step(time_style_i, k == KEY_PLUS, held, evt_i.coarse, time_d);
            edited = 1'b1;
            blink  = BLINK_EDIT;
          end
          default: begin
            double_b = 1'b1;
          end
        endcase
      end
    end
    if (evt_i.action_short[0]) begin
      run_d   = !run_q;
      started = !run_q;
      mode_d  = MODE_NONE;
      short_b = 1'b1;
    end
    if (evt_i.action_short[1]) begin
      mode_d  = (mode_d >= MODE_TIME) ? MODE_NONE : mode_d + 2'd1;
      blink   = BLINK_MENU;
      short_b = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      speed_q     <= SPEED_MIN;
      time_q      <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q      <= mode_d;
        speed_q     <= speed_d;
        time_q      <= time_d;
        run_q       <= run_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_o.speed_setpoint <= speed_d;
      result_o.time_setpoint  <= time_d;
      result_o.edit_mode      <= mode_d;
      result_o.running        <= run_d;
      result_o.run_started    <= started;
      result_o.value_edited   <= edited;
      result_o.blink_code     <= blink;
      result_o.short_beep     <= short_b;
      result_o.double_beep    <= double_b;
    end
  end

  assign result_o.valid = out_valid_q;

endmodule

>>> sv/keypad_setpoint_editor.sv
// Keypad setpoint editor.
// tick_i takes one request per key scan: four active-low key levels and the
// coarse-unit flag. result_o gives one result per request, in order: speed and
// time setpoints, edit mode, run flag and the beep, blink and edit pulses.
// Both channels use valid/ready; a request is taken when both are high.
// The APB port sets tick_ms (0x0) and time_style (0x4); write only while idle.
// Events pass through the queue into the result register. One request per
// cycle is taken while the queue has room. The front stage updates the hold
// timers and classifies key events in the accept cycle; the back stage applies
// them to the setpoints one entry per cycle, while results are taken, from a
// two-entry event queue. When the receiver stalls, the result register holds,
// the queue fills and tick_i.ready drops after two further requests.
// Reset clears all hold timers, mode 0, speed 10, time 0, not running,
// tick_ms 10, time_style 0; no clearing pass is needed.
`include "keypad_setpoint_editor_assert.svh"

module keypad_setpoint_editor #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kse_tick_if.sink    tick_i,
  kse_result_if.source result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kse_pkg::*;

  logic [9:0] tick_ms_q;
  logic       time_style_q;
  logic       cfg_we;
  logic       push, pop, q_full, q_empty;
  kse_evt_t   evt_push, evt_pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q    <= TICK_MS_RST;
      time_style_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_TICK_MS:    tick_ms_q    <= pwdata[9:0];
        REG_TIME_STYLE: time_style_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TICK_MS:    prdata = {22'd0, tick_ms_q};
      REG_TIME_STYLE: prdata = {31'd0, time_style_q};
      default:        prdata = '0;
    endcase
  end

  kse_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_i),
    .tick_ms_i(tick_ms_q),
    .q_full_i (q_full),
    .push_o   (push),
    .evt_o    (evt_push)
  );

  kse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(evt_push),
    .pop_i      (pop),
    .pop_data_o (evt_pop),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  kse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .time_style_i(time_style_q),
    .evt_i       (evt_pop),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .result_o    (result_o)
  );

  `KSE_ASSERT_NXT(a_push_lands, push, !q_empty, "accepted tick missing from event queue")
  `KSE_ASSERT_IMP(a_start_on, result_o.valid && result_o.run_started,
                  result_o.running && result_o.short_beep, "run_started without run")
  `KSE_ASSERT_IMP(a_ranges, result_o.valid,
                  result_o.speed_setpoint >= SPEED_MIN && result_o.speed_setpoint <= SPEED_MAX
                  && result_o.time_setpoint <= TIME_LIMIT && result_o.edit_mode != 2'd3,
                  "setpoint out of range")
  `KSE_ASSERT_IMP(a_edit_blink, result_o.valid && result_o.value_edited,
                  result_o.blink_code != BLINK_NONE, "edit without blink")

endmodule

>>> test/tb_keypad_setpoint_editor.sv
`timescale 1ns / 1ps

module tb_keypad_setpoint_editor;
  import kse_pkg::*;

  localparam int TIMER_BITS   = 16;
  localparam int HOLD_SAT     = (1 << TIMER_BITS) - 1;
  localparam int TOTAL_TICKS  = 1150;
  localparam int STALL_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 20;

  localparam int unsigned KEY_START = 2;
  localparam int unsigned KEY_MENU  = 3;
  localparam int LATCH_START = 0;
  localparam int LATCH_MENU  = 1;

  localparam bit [3:0] DOWN_MINUS = 4'b0001;
  localparam bit [3:0] DOWN_PLUS  = 4'b0010;
  localparam bit [3:0] DOWN_START = 4'b0100;
  localparam bit [3:0] DOWN_MENU  = 4'b1000;
  localparam bit [3:0] ALL_UP     = 4'b1111;

  localparam int TIME_MAX_SEC = 5940;
  localparam int HOUR_S       = 3600;
  localparam int TEN_MIN_S    = 600;
  localparam int MIN_S        = 60;
  localparam int FINE_HELD_S  = 10;

  typedef struct packed {
    logic [6:0]  speed_sp;
    logic [14:0] time_sp;
    logic [1:0]  mode;
    logic        running;
    logic        started;
    logic        edited;
    logic [1:0]  blink;
    logic        beep_short;
    logic        beep_double;
  } tick_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kse_tick_if   tick_if ();
  kse_result_if res_if ();

  keypad_setpoint_editor #(
    .TIMER_BITS(TIMER_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_if),
    .result_o(res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  int unsigned hold_ms [4];
  bit          key_pressed [4];
  bit          beep_latched [2];
  logic [1:0]  mode_q;
  int          speed_q;
  int          time_q;
  bit          run_q;
  logic [9:0]  tick_ms_q;
  bit          style_q;
  bit          flag_started, flag_edited, flag_short, flag_double;
  logic [1:0]  flag_blink;

  tick_result_t pending_results[$];

  int n_sent;
  int n_checked;
  int n_errors;
  int n_steps;
  int n_doubles;
  int n_configs;
  int src_idle_pct;
  int rcv_idle_pct;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_predictor();
    for (int k = 0; k < 4; k++) begin
      hold_ms[k]     = 0;
      key_pressed[k] = 1'b0;
    end
    beep_latched[LATCH_START] = 1'b0;
    beep_latched[LATCH_MENU]  = 1'b0;
    mode_q    = MODE_NONE;
    speed_q   = int'(SPEED_MIN);
    time_q    = 0;
    run_q     = 1'b0;
    tick_ms_q = TICK_MS_RST;
    style_q   = 1'b0;
  endfunction

  function automatic void add_hold(int unsigned k);
    int unsigned t;
    t = hold_ms[k] + tick_ms_q;
    hold_ms[k] = (t > HOLD_SAT) ? HOLD_SAT : t;
  endfunction

  function automatic void step_time(bit up, bit held, bit coarse);
    int t;
    t = time_q;
    if (style_q) begin
      if (up) begin
        if (coarse) t += HOUR_S;
        else if (held) begin
          t += TEN_MIN_S;
          if (t > HOUR_S) t = HOUR_S;
        end else t += MIN_S;
        if (t > int'(TIME_LIMIT)) t = int'(TIME_LIMIT);
      end else begin
        if (coarse) t -= (t == HOUR_S) ? MIN_S : HOUR_S;
        else t -= held ? TEN_MIN_S : MIN_S;
        if (t < MIN_S) t = 0;
      end
    end else begin
      if (up) begin
        // from zero a fine step lands on a whole minute
        if (t == 0) t += held ? MIN_S : MIN_S - 1;
        if (!coarse) begin
          t += held ? FINE_HELD_S : 1;
          if (held && t > MIN_S) t = MIN_S;
        end else begin
          t += held ? TEN_MIN_S : MIN_S;
        end
        if (t > TIME_MAX_SEC) t = TIME_MAX_SEC;
      end else begin
        if (held) t -= coarse ? TEN_MIN_S : FINE_HELD_S;
        else t -= (t <= MIN_S) ? 1 : MIN_S;
        if (t < 1) t = 0;
      end
    end
    time_q = t;
  endfunction

  function automatic void edit_value(bit up, bit held, bit coarse);
    int d;
    if (mode_q == MODE_SPEED) begin
      d = held ? int'(SPEED_COARSE) : int'(SPEED_FINE);
      speed_q += up ? d : -d;
      if (speed_q < int'(SPEED_MIN)) speed_q = int'(SPEED_MIN);
      if (speed_q > int'(SPEED_MAX)) speed_q = int'(SPEED_MAX);
    end else if (mode_q == MODE_TIME) begin
      step_time(up, held, coarse);
    end else begin
      flag_double = 1'b1;
      return;
    end
    flag_edited = 1'b1;
    flag_blink  = BLINK_EDIT;
  endfunction

  function automatic void arrow_key(int unsigned k, bit up, bit level, bit coarse);
    if (!level) begin
      add_hold(k);
      key_pressed[k] = 1'b1;
    end
    if (key_pressed[k]) begin
      if (level) begin
        if (hold_ms[k] < SHORT_MS) edit_value(up, 1'b0, coarse);
        key_pressed[k] = 1'b0;
        hold_ms[k]     = 0;
      end
      // repeat window; timer drops back so the step comes again
      if (hold_ms[k] > REPEAT_LOW_MS && hold_ms[k] < REPEAT_HIGH_MS) begin
        edit_value(up, 1'b1, coarse);
        key_pressed[k] = 1'b0;
        hold_ms[k]     = SHORT_MS;
      end
    end
  endfunction

  function automatic void action_key(int unsigned k, int l, bit level);
    if (!level && !beep_latched[l]) begin
      add_hold(k);
      key_pressed[k] = 1'b1;
    end
    if (key_pressed[k]) begin
      if (level) begin
        if (hold_ms[k] < SHORT_MS) begin
          if (k == KEY_START) begin
            if (!run_q) begin
              run_q        = 1'b1;
              flag_started = 1'b1;
            end else begin
              run_q = 1'b0;
            end
            mode_q = MODE_NONE;
          end else begin
            mode_q     = (mode_q >= MODE_TIME) ? MODE_NONE : 2'(mode_q + 2'd1);
            flag_blink = BLINK_MENU;
          end
          flag_short = 1'b1;
        end
        key_pressed[k]  = 1'b0;
        beep_latched[l] = 1'b0;
        hold_ms[k]      = 0;
      end
      if (hold_ms[k] > SHORT_MS && hold_ms[k] < HOLD_END_MS && !beep_latched[l]) begin
        flag_double     = 1'b1;
        beep_latched[l] = 1'b1;
      end
    end
  endfunction

  function automatic tick_result_t predict_tick(bit [3:0] levels, bit coarse);
    tick_result_t r;
    flag_started = 1'b0;
    flag_edited  = 1'b0;
    flag_short   = 1'b0;
    flag_double  = 1'b0;
    flag_blink   = BLINK_NONE;
    arrow_key(KEY_MINUS, 1'b0, levels[KEY_MINUS], coarse);
    arrow_key(KEY_PLUS, 1'b1, levels[KEY_PLUS], coarse);
    action_key(KEY_START, LATCH_START, levels[KEY_START]);
    action_key(KEY_MENU, LATCH_MENU, levels[KEY_MENU]);
    r.speed_sp    = 7'(speed_q);
    r.time_sp     = 15'(time_q);
    r.mode        = mode_q;
    r.running     = run_q;
    r.started     = flag_started;
    r.edited      = flag_edited;
    r.blink       = flag_blink;
    r.beep_short  = flag_short;
    r.beep_double = flag_double;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_tick(bit [3:0] levels, bit coarse);
    tick_result_t r;
    if (n_sent < TOTAL_TICKS / 3) begin
      src_idle_pct = 27;
      rcv_idle_pct = 53;
    end else if (n_sent < 2 * TOTAL_TICKS / 3) begin
      src_idle_pct = 53;
      rcv_idle_pct = 27;
    end else begin
      src_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    // each idle cycle is drawn on its own, so the idle share matches the percentage
    while ($urandom_range(99) < src_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid           <= 1'b1;
    tick_if.key_minus_level <= levels[KEY_MINUS];
    tick_if.key_plus_level  <= levels[KEY_PLUS];
    tick_if.key_start_level <= levels[KEY_START];
    tick_if.key_menu_level  <= levels[KEY_MENU];
    tick_if.coarse_unit     <= coarse;
    do @(posedge clk_i); while (tick_if.ready !== 1'b1);
    r = predict_tick(levels, coarse);
    if (r.edited) n_steps++;
    if (r.beep_double) n_doubles++;
    pending_results.push_back(r);
    n_sent++;
  endtask

  task automatic tap(bit [3:0] down, int hold_ticks, bit coarse);
    repeat (hold_ticks) send_tick(~down, coarse);
    send_tick(ALL_UP, coarse);
  endtask

  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [9:0] tick_ms, bit style);
    wait_idle();
    write_reg({REG_TICK_MS, 2'b00}, {22'd0, tick_ms});
    tick_ms_q = tick_ms;
    write_reg({REG_TIME_STYLE, 2'b00}, {31'd0, style});
    style_q = style;
    n_configs++;
  endtask

  // ---------------------------------------------------------------- receiver and checks

  always @(posedge clk_i) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    tick_result_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t ns: result with nothing expected, expected none, got speed %0d time %0d",
                   $time, res_if.speed_setpoint, res_if.time_setpoint);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        compare_field("speed_setpoint", 16'(want.speed_sp), 16'(res_if.speed_setpoint));
        compare_field("time_setpoint", 16'(want.time_sp), 16'(res_if.time_setpoint));
        compare_field("edit_mode", 16'(want.mode), 16'(res_if.edit_mode));
        compare_field("running", 16'(want.running), 16'(res_if.running));
        compare_field("run_started", 16'(want.started), 16'(res_if.run_started));
        compare_field("value_edited", 16'(want.edited), 16'(res_if.value_edited));
        compare_field("blink_code", 16'(want.blink), 16'(res_if.blink_code));
        compare_field("short_beep", 16'(want.beep_short), 16'(res_if.short_beep));
        compare_field("double_beep", 16'(want.beep_double), 16'(res_if.double_beep));
      end
    end
  end

  // no request or result moving for too long means the block has hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                   $time, STALL_LIMIT, pending_results.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_short_presses();
    set_config(10'd500, 1'b0);
    tap(DOWN_MINUS, 1, 1'b0);             // edit with no mode selected
    tap(DOWN_MENU, 1, 1'b0);              // speed mode
    tap(DOWN_MINUS | DOWN_PLUS, 1, 1'b0); // both arrows, minus clamps at the floor
    tap(DOWN_MENU, 3, 1'b0);              // released at exactly 1.5 s: nothing
    tap(DOWN_START, 4, 1'b0);             // hold beep, no toggle
    tap(DOWN_START, 1, 1'b0);
    tap(DOWN_START, 1, 1'b0);
  endtask

  task automatic test_repeats();
    set_config(10'd1000, 1'b1);
    tap(DOWN_MENU, 1, 1'b0);
    tap(DOWN_MENU, 1, 1'b0);
    tap(DOWN_PLUS, 2, 1'b1);              // coarse repeat, released on the next tick
    tap(DOWN_PLUS, 1, 1'b0);              // timer resumes from 1.5 s
    tap(DOWN_MENU | DOWN_PLUS, 1, 1'b0);  // menu blink overrides edit blink
  endtask

  task automatic test_time_limits();
    tap(DOWN_MENU, 1, 1'b0);
    tap(DOWN_MENU, 1, 1'b0);
    set_config(10'd700, 1'b0);
    tap(DOWN_MINUS, 4, 1'b0);             // timer steps over the repeat window
    set_config(10'd0, 1'b1);
    tap(DOWN_MINUS, 2, 1'b1);
    tap(DOWN_MINUS, 2, 1'b1);
    set_config(10'd1023, 1'b0);
    tap(DOWN_PLUS, 2, 1'b0);              // held step up from zero
  endtask

  task automatic random_gesture();
    int          r;
    int          target_ms;
    int          n;
    bit [3:0]    down;
    bit [3:0]    levels;
    bit          coarse;
    coarse = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 10) begin
      send_tick(4'($urandom), 1'($urandom_range(1)));
      return;
    end
    r = $urandom_range(99);
    if (r < 30) down = DOWN_MINUS;
    else if (r < 60) down = DOWN_PLUS;
    else if (r < 75) down = DOWN_MENU;
    else if (r < 85) down = DOWN_START;
    else down = 4'($urandom_range(1, 15));
    r = $urandom_range(99);
    if (r < 55) target_ms = $urandom_range(0, 1400);
    else if (r < 85) target_ms = $urandom_range(1500, 2600);
    else if (r < 94) target_ms = $urandom_range(2600, 6000);
    else target_ms = 70000;
    n = (tick_ms_q == 0) ? $urandom_range(1, 4) : target_ms / int'(tick_ms_q) + 1;
    if (n > 80) n = 80;
    for (int i = 0; i < n; i++) begin
      levels = ~down;
      if ($urandom_range(99) < 3) levels = 4'($urandom);  // key bounce
      if ($urandom_range(99) < 15) coarse = ~coarse;
      send_tick(levels, coarse);
    end
    repeat ($urandom_range(1, 2)) send_tick(ALL_UP, coarse);
  endtask

  task automatic test_random_ticks();
    int          phase;
    int          phase_end;
    logic [9:0]  tick_ms;
    bit          style;
    logic [9:0]  tick_choices [12];
    tick_choices = '{10'd1023, 10'd100, 10'd1000, 10'd250, 10'd0, 10'd37,
                     10'd1, 10'd500, 10'd64, 10'd1000, 10'd200, 10'd150};
    phase = 0;
    while (n_sent < TOTAL_TICKS) begin
      tick_ms = tick_choices[phase % 12];
      if (phase % 4 == 3) tick_ms = 10'($urandom_range(1, 1000));
      style = (phase < 2) ? 1'(phase) : 1'($urandom_range(1));
      set_config(tick_ms, style);
      // saturate a hold timer once at the largest tick
      if (phase == 0) tap(DOWN_MINUS, 66, 1'b0);
      phase_end = n_sent + 100;
      while (n_sent < phase_end && n_sent < TOTAL_TICKS) random_gesture();
      phase++;
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    tick_if.valid           = 1'b0;
    tick_if.key_minus_level = 1'b1;
    tick_if.key_plus_level  = 1'b1;
    tick_if.key_start_level = 1'b1;
    tick_if.key_menu_level  = 1'b1;
    tick_if.coarse_unit     = 1'b0;
    n_sent       = 0;
    n_checked    = 0;
    n_errors     = 0;
    n_steps      = 0;
    n_doubles    = 0;
    n_configs    = 0;
    stall_cycles = 0;
    src_idle_pct = 27;
    rcv_idle_pct = 53;
    reset_predictor();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_presses();
    test_repeats();
    test_time_limits();
    test_random_ticks();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) n_errors++;

    $display("Sent %0d key scans, checked %0d results: %0d setpoint steps, %0d double beeps.",
             n_sent, n_checked, n_steps, n_doubles);
    $display("%0d register settings, tick 0 to 1023 ms, both time styles, mismatches: %0d.",
             n_configs, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
